/* sv/assert_macros.svh */
// Assertion macros used by gft_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a consequence in the next cycle.
`define CHK_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`endif

/* sv/gft_pkg.sv */
// Shared types and constants of the face transmissibility block.
// No dependencies.
package gft_pkg;
    localparam int DEF_MAX_NX = 64;
    localparam int DEF_MAX_NY = 64;
    localparam int DEF_MAX_NZ = 64;
    localparam int CELL_W = 18;
    localparam int PERM_W = 32;
    localparam int TRANS_W = 48;
    localparam int DD_W = 33;
    localparam int DIM_W = 7;
    localparam int CFG_W = 32;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_CELLS_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CELLS_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_CELLS_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_GEOM_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_GEOM_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_GEOM_Z  = 3'd5;

    localparam logic [1:0] DIR_X = 2'd0;
    localparam logic [1:0] DIR_Y = 2'd1;
    localparam logic [1:0] DIR_Z = 2'd2;

    // one face job handed to the divider
    typedef struct packed {
        logic [PERM_W-1:0]  a;
        logic [PERM_W-1:0]  b;
        logic [PERM_W-1:0]  geom;
        logic [CELL_W-1:0]  lower;
        logic [CELL_W-1:0]  upper;
        logic [1:0]         dir;
        logic [DD_W-1:0]    dd;
        logic               last;
    } face_t;
endpackage

/* sv/grid_face_transmissibility.sv */
// Face transmissibility over a raster-ordered grid, one cell a beat.
// Each face takes a bit-serial divide of a 64-bit product in the face unit; the faces of a cell
// run one after another, since the one divider serves every face, and the next cell waits for them.
// Reset: counters and config to defaults; row and plane stores stay unwritten.
// Depends on gft_pkg, gft_ram, gft_face_unit.
module grid_face_transmissibility import gft_pkg::*; #(
    parameter int MAX_NX = DEF_MAX_NX,
    parameter int MAX_NY = DEF_MAX_NY,
    parameter int MAX_NZ = DEF_MAX_NZ
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PERM_W-1:0]   perm_x,
    input  logic [PERM_W-1:0]   perm_y,
    input  logic [PERM_W-1:0]   perm_z,
    input  logic signed [PERM_W-1:0] cell_depth,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CELL_W-1:0]   lower_cell,
    output logic [CELL_W-1:0]   upper_cell,
    output logic [1:0]          direction,
    output logic [TRANS_W-1:0]  transmissibility,
    output logic signed [DD_W-1:0] depth_difference,
    output logic                last
);
    localparam int XW = $clog2(MAX_NX);
    localparam int YW = (MAX_NY > 1) ? $clog2(MAX_NY) : 1;
    localparam int PW = XW + YW;
    localparam int PLANE = 1 << PW;
    localparam int CW = 11;

    typedef enum logic [2:0] {C_IDLE, C_READ, C_FX, C_FY, C_FZ, C_WAIT} ctl_t;

    logic [DIM_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [CFG_W-1:0] gx_reg, gy_reg, gz_reg;
    logic [CW-1:0] nx, ny, nz;
    logic [CW-1:0] px_reg, py_reg, pz_reg;
    logic [CELL_W-1:0] li_reg;
    logic [PERM_W-1:0] prev_reg;
    logic [PERM_W-1:0] ipx_reg, ipy_reg, ipz_reg, idep_reg;
    ctl_t st_reg;

    logic [XW-1:0] xi;
    logic [PW-1:0] pidx;
    logic [PERM_W-1:0] row_q;
    logic [2*PERM_W-1:0] plane_q;
    logic row_we, plane_we;

    logic fu_start, fu_busy, fu_done;
    face_t job, res_face;
    logic [TRANS_W-1:0] res_trans;
    logic has_x, has_y, has_z;

    function automatic logic [CW-1:0] clampd(logic [DIM_W-1:0] v, int m);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w == '0) return CW'(1);
        if (w > CW'(m)) return CW'(m);
        return w;
    endfunction

    assign nx = clampd(cx_reg, MAX_NX);
    assign ny = clampd(cy_reg, MAX_NY);
    assign nz = clampd(cz_reg, MAX_NZ);
    assign xi = px_reg[XW-1:0];
    assign pidx = {py_reg[YW-1:0], xi};
    assign has_x = (px_reg != '0);
    assign has_y = (py_reg != '0);
    assign has_z = (pz_reg != '0);

    // store the cell only when it retires, so the neighbor reads stay stable meanwhile
    assign row_we = (st_reg == C_WAIT) && !fu_busy && !out_valid;
    assign plane_we = (st_reg == C_WAIT) && !fu_busy && !out_valid;

    gft_ram #(.WIDTH(PERM_W), .DEPTH(MAX_NX)) u_row (
        .clk(clk), .we(row_we), .waddr(xi), .wdata(ipy_reg),
        .raddr(xi), .rdata(row_q)
    );

    gft_ram #(.WIDTH(2 * PERM_W), .DEPTH(PLANE)) u_plane (
        .clk(clk), .we(plane_we), .waddr(pidx), .wdata({idep_reg, ipz_reg}),
        .raddr(pidx), .rdata(plane_q)
    );

    gft_face_unit u_face (
        .clk(clk), .rst_n(rst_n), .start(fu_start), .job(job),
        .busy(fu_busy), .done(fu_done), .res_face(res_face), .res_trans(res_trans)
    );

    assign in_ready = (st_reg == C_IDLE);

    // build the face job for the current state
    always_comb
    begin
        job = '0;
        job.upper = li_reg;
        fu_start = 1'b0;
        case (st_reg)
            C_FX:
            begin
                job.a = prev_reg; job.b = ipx_reg; job.geom = gx_reg;
                job.lower = li_reg - CELL_W'(1); job.dir = DIR_X;
                job.last = !has_y && !has_z;
                fu_start = !fu_busy && !out_valid;
            end
            C_FY:
            begin
                job.a = row_q; job.b = ipy_reg; job.geom = gy_reg;
                job.lower = li_reg - CELL_W'(nx); job.dir = DIR_Y;
                job.last = !has_z;
                fu_start = !fu_busy && !out_valid;
            end
            C_FZ:
            begin
                job.a = plane_q[PERM_W-1:0]; job.b = ipz_reg; job.geom = gz_reg;
                job.lower = li_reg - CELL_W'(nx) * CELL_W'(ny); job.dir = DIR_Z;
                job.dd = {idep_reg[PERM_W-1], idep_reg}
                       - {plane_q[2*PERM_W-1], plane_q[2*PERM_W-1:PERM_W]};
                job.last = 1'b1;
                fu_start = !fu_busy && !out_valid;
            end
            default:
            begin
                fu_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= DIM_W'(64); cy_reg <= DIM_W'(64); cz_reg <= DIM_W'(64);
            gx_reg <= 32'h10000; gy_reg <= 32'h10000; gz_reg <= 32'h10000;
            px_reg <= '0; py_reg <= '0; pz_reg <= '0; li_reg <= '0;
            st_reg <= C_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CELLS_X: cx_reg <= cfg_data[DIM_W-1:0];
                    REG_CELLS_Y: cy_reg <= cfg_data[DIM_W-1:0];
                    REG_CELLS_Z: cz_reg <= cfg_data[DIM_W-1:0];
                    REG_GEOM_X:  gx_reg <= cfg_data;
                    REG_GEOM_Y:  gy_reg <= cfg_data;
                    REG_GEOM_Z:  gz_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (fu_done)
            begin
                out_valid <= 1'b1;
                lower_cell <= res_face.lower;
                upper_cell <= res_face.upper;
                direction <= res_face.dir;
                transmissibility <= res_trans;
                depth_difference <= res_face.dd;
                last <= res_face.last;
            end
            case (st_reg)
                C_IDLE:
                begin
                    if (in_valid)
                    begin
                        ipx_reg <= perm_x; ipy_reg <= perm_y;
                        ipz_reg <= perm_z; idep_reg <= cell_depth;
                        st_reg <= C_READ;
                    end
                end
                C_READ:
                begin
                    // wait in this state so the registered neighbor reads of this position have landed
                    st_reg <= has_x ? C_FX : (has_y ? C_FY : (has_z ? C_FZ : C_WAIT));
                end
                C_FX:
                begin
                    if (fu_start)
                    begin
                        st_reg <= has_y ? C_FY : (has_z ? C_FZ : C_WAIT);
                    end
                end
                C_FY:
                begin
                    if (fu_start)
                    begin
                        st_reg <= has_z ? C_FZ : C_WAIT;
                    end
                end
                C_FZ:
                begin
                    if (fu_start)
                    begin
                        st_reg <= C_WAIT;
                    end
                end
                C_WAIT:
                begin
                    // drain the last face, then advance the raster position
                    if (!fu_busy && !out_valid)
                    begin
                        prev_reg <= ipx_reg;
                        st_reg <= C_IDLE;
                        if (px_reg + CW'(1) < nx)
                        begin
                            px_reg <= px_reg + CW'(1); li_reg <= li_reg + CELL_W'(1);
                        end
                        else
                        begin
                            px_reg <= '0;
                            if (py_reg + CW'(1) < ny)
                            begin
                                py_reg <= py_reg + CW'(1); li_reg <= li_reg + CELL_W'(1);
                            end
                            else
                            begin
                                py_reg <= '0;
                                if (pz_reg + CW'(1) < nz)
                                begin
                                    pz_reg <= pz_reg + CW'(1);
                                    li_reg <= li_reg + CELL_W'(1);
                                end
                                else
                                begin
                                    pz_reg <= '0; li_reg <= '0;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    st_reg <= C_IDLE;
                end
            endcase
        end
    end
endmodule

/* sv/gft_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/gft_face_unit.sv */
// Harmonic-mean transmissibility for one face: restoring divider, one quotient bit a cycle.
// Depends on gft_pkg.
module gft_face_unit import gft_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  face_t               job,
    output logic                busy,
    output logic                done,
    output face_t               res_face,
    output logic [TRANS_W-1:0]  res_trans
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_ROUND, S_GMUL, S_DONE} st_t;
    localparam int P_W = 2 * PERM_W;
    localparam int S_W = PERM_W + 1;

    st_t               st_reg;
    face_t             f_reg;
    logic [P_W-1:0]    p_reg;
    logic [S_W-1:0]    s_reg;
    logic [S_W:0]      r_reg;
    logic [P_W-1:0]    q_reg;
    logic [6:0]        cnt_reg;
    logic [PERM_W-1:0] h_reg;
    logic [P_W-1:0]    hg_reg;
    logic [S_W:0]      r_shift;
    logic [S_W+1:0]    r2;

    assign r_shift = {r_reg[S_W-1:0], p_reg[P_W-1]};
    assign r2 = {r_reg, 1'b0};
    assign busy = (st_reg != S_IDLE);
    assign done = (st_reg == S_DONE);
    assign res_face = f_reg;
    assign res_trans = hg_reg[P_W-1:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        f_reg <= job;
                        s_reg <= {1'b0, job.a} + {1'b0, job.b};
                        st_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    p_reg <= f_reg.a * f_reg.b;
                    r_reg <= '0;
                    q_reg <= '0;
                    cnt_reg <= 7'(P_W);
                    st_reg <= (s_reg == '0) ? S_GMUL : S_DIV;
                    h_reg <= '0;
                end
                S_DIV:
                begin
                    // shift in one dividend bit, subtract when it fits
                    if (r_shift >= {1'b0, s_reg})
                    begin
                        r_reg <= r_shift - {1'b0, s_reg};
                        q_reg <= {q_reg[P_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r_shift;
                        q_reg <= {q_reg[P_W-2:0], 1'b0};
                    end
                    p_reg <= {p_reg[P_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        st_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    h_reg <= PERM_W'({q_reg[PERM_W-1:0], 1'b0}
                             + {{PERM_W{1'b0}}, (r2 >= {2'b0, s_reg})});
                    st_reg <= S_GMUL;
                end
                S_GMUL:
                begin
                    hg_reg <= h_reg * f_reg.geom;
                    st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    st_reg <= S_IDLE;
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* sv/gft_checker.sv */
// Port-level checks on the face transmissibility block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module gft_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] direction,
    input logic       last
);
    `CHK_ALWAYS(a_dir_range, clk, rst_n, !out_valid || direction != 2'd3, "bad direction")
    `CHK_ALWAYS(a_z_last, clk, rst_n, !out_valid || direction != 2'd2 || last, "z face not last")
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "beat dropped")
    `CHK_NEXT(a_no_take, clk, rst_n, in_valid && in_ready, !in_ready, "second cell taken")
endmodule

bind grid_face_transmissibility gft_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .direction(direction), .last(last)
);
